// ===== sv/sgac_pkg.sv =====
package sgac_pkg;

   localparam logic [1:0] OP_M = 2'd0;
   localparam logic [1:0] OP_X = 2'd1;
   localparam logic [1:0] OP_I = 2'd2;
   localparam logic [1:0] OP_D = 2'd3;

   localparam logic [1:0] CSR_SUB_LOW  = 2'd0;
   localparam logic [1:0] CSR_SUB_HIGH = 2'd1;
   localparam logic [1:0] CSR_GAP      = 2'd2;

   localparam int POS_W = 11;
   localparam int LEN_W = 11;
   localparam int RUN_W = LEN_W + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_TB_RD,
      ST_TB_STEP,
      ST_FLUSH,
      ST_HDR,
      ST_RUNS
   } state_type;

   typedef struct packed {
      logic       valid;
      logic       init;
      logic [1:0] sym;
   } cell_ctl_type;

   function automatic logic signed [7:0] sub_score(input logic [127:0] tbl,
                                                   input logic [1:0] p,
                                                   input logic [1:0] t);
      logic [3:0] k;
      k = {p, t};
      return tbl[k*8 +: 8];
   endfunction

   function automatic logic signed [7:0] gap_score(input logic [31:0] tbl,
                                                   input logic [1:0] s);
      return tbl[s*8 +: 8];
   endfunction

endpackage

// ===== sv/sgac_if.sv =====
interface sgac_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [1:0] symbol;
   logic       last;

   modport source (output valid, req_type, symbol, last, input ready);
   modport sink (input valid, req_type, symbol, last, output ready);
endinterface

interface sgac_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [15:0] score;
   logic [10:0]        start_pos;
   logic [1:0]         op;
   logic [10:0]        run_length;
   logic               final_res;

   modport source (output valid, kind, score, start_pos, op, run_length, final_res,
                   input ready);
   modport sink (input valid, kind, score, start_pos, op, run_length, final_res,
                 output ready);
endinterface

// ===== sv/sgac_ram.sv =====
module sgac_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== sv/sgac_cell.sv =====
module sgac_cell #(
   parameter int SCORE_BITS = 16,
   parameter int TEXT_LEN   = 1024,
   parameter int AW         = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pat_we,
   input  logic [1:0]                   pat_sym,
   input  logic [127:0]                 sub_table,
   input  logic [31:0]                  gap_table,
   input  sgac_pkg::cell_ctl_type       in_ctl,
   input  logic [AW-1:0]                in_col,
   input  logic signed [SCORE_BITS-1:0] in_new,
   input  logic signed [SCORE_BITS-1:0] in_old,
   input  logic [AW-1:0]                rd_addr,
   output sgac_pkg::cell_ctl_type       out_ctl,
   output logic [AW-1:0]                out_col,
   output logic signed [SCORE_BITS-1:0] out_new,
   output logic signed [SCORE_BITS-1:0] out_old,
   output logic [1:0]                   rd_dir
);
   import sgac_pkg::*;

   localparam int SW = SCORE_BITS + 2;
   localparam logic signed [SW-1:0] SMAX = (SW'(1) <<< (SCORE_BITS - 1)) - SW'(1);
   localparam logic signed [SW-1:0] SMIN = ~SMAX;

   function automatic logic signed [SCORE_BITS-1:0] sat(input logic signed [SW-1:0] x);
      if (x > SMAX) return SMAX[SCORE_BITS-1:0];
      if (x < SMIN) return SMIN[SCORE_BITS-1:0];
      return x[SCORE_BITS-1:0];
   endfunction

   logic [1:0]                   pat_ff;
   logic signed [SCORE_BITS-1:0] own_ff;
   logic signed [7:0]            gap_p, gap_t, sub_s;
   logic signed [SCORE_BITS-1:0] own_cur, new_score;
   logic signed [SW-1:0]         del_v, ins_v, mm_v, best_v;
   logic [1:0]                   dir;

   always_comb begin
      gap_p   = gap_score(gap_table, pat_ff);
      gap_t   = gap_score(gap_table, in_ctl.sym);
      sub_s   = sub_score(sub_table, pat_ff, in_ctl.sym);
      own_cur = in_ctl.init ? sat(SW'(in_old) + SW'(gap_p)) : own_ff;
      del_v   = SW'(in_new) + SW'(gap_p);
      ins_v   = SW'(own_cur) + SW'(gap_t);
      mm_v    = SW'(in_old) + SW'(sub_s);
      if (del_v > ins_v) begin
         best_v = del_v;
         dir    = OP_D;
      end else begin
         best_v = ins_v;
         dir    = OP_I;
      end
      if (!(best_v > mm_v)) begin
         best_v = mm_v;
         dir    = (pat_ff == in_ctl.sym) ? OP_M : OP_X;
      end
      new_score = sat(best_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ctl <= '0;
      end else begin
         out_ctl <= in_ctl;
      end
      if (pat_we) begin
         pat_ff <= pat_sym;
      end
      if (in_ctl.valid) begin
         own_ff <= new_score;
      end
      out_col <= in_col;
      out_new <= new_score;
      out_old <= own_cur;
   end

   sgac_ram #(.WIDTH(2), .DEPTH(TEXT_LEN)) u_dir_ram (
      .clock (clock),
      .we    (in_ctl.valid),
      .waddr (in_col),
      .wdata (dir),
      .raddr (rd_addr),
      .rdata (rd_dir)
   );
endmodule

// ===== sv/semiglobal_alignment_cigar.sv =====
// channel  dir  handshake        payload
// req      in   valid & ready    req_type, symbol, last
// rsp      out  valid & ready    kind, score, start_pos, op, run_length, final_res
// csr      in   csr_we           csr_index, csr_wdata
//
// A text item enters the cell row in the cycle after it is taken; each cell registers it for
// the next, so text items stream at one per cycle while idle. A last text item is followed by
// a drain until the cell row is empty, then traceback steps (direction RAM read, then step),
// a flush, then result items at one per cycle when rsp is not stalled. Pattern items wait
// until the cell row is empty. Reset is synchronous; no clearing pass. Input is held from a
// last text item until the last result item is loaded, so a stalled rsp also holds off req.
module semiglobal_alignment_cigar #(
   parameter int PAT_LEN    = 16,
   parameter int TEXT_LEN   = 1024,
   parameter int ALPHABET   = 4,
   parameter int SCORE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   sgac_req_if.sink          req,
   sgac_rsp_if.source        rsp,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_wdata
);
   import sgac_pkg::*;

   localparam int AW    = TEXT_LEN > 1 ? $clog2(TEXT_LEN) : 1;
   localparam int PW    = $clog2(TEXT_LEN + 1);
   localparam int CW    = $clog2(PAT_LEN + 1);
   localparam int RIW   = PAT_LEN > 1 ? $clog2(PAT_LEN) : 1;
   localparam int MAXRUNS = 2 * PAT_LEN;
   localparam int RW    = $clog2(MAXRUNS);
   localparam int NW    = $clog2(MAXRUNS + 1);

   logic [63:0]                  sub_lo_ff, sub_hi_ff;
   logic [31:0]                  gap_ff;
   logic [CW-1:0]                count_ff;
   logic                         closed_ff;
   logic [PW-1:0]                tpos_ff;
   logic signed [SCORE_BITS-1:0] best_ff;
   logic [PW-1:0]                bcol_ff;
   cell_ctl_type                 inj_ctl_ff;
   logic [AW-1:0]                inj_col_ff;
   state_type                    state_ff, state_in;
   logic [CW-1:0]                tb_i_ff;
   logic [PW-1:0]                tb_c_ff;
   logic [1:0]                   cur_op_ff;
   logic [LEN_W-1:0]             cur_len_ff;
   logic                         cur_has_ff;
   logic [RUN_W-1:0]             runs_ff [MAXRUNS];
   logic [NW-1:0]                nruns_ff, r_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_kind_ff, rsp_final_ff;
   logic signed [15:0]           rsp_score_ff;
   logic [POS_W-1:0]             rsp_start_ff;
   logic [1:0]                   rsp_op_ff;
   logic [LEN_W-1:0]             rsp_len_ff;

   cell_ctl_type                 link_ctl [PAT_LEN+1];
   logic [AW-1:0]                link_col [PAT_LEN+1];
   logic signed [SCORE_BITS-1:0] link_new [PAT_LEN+1];
   logic signed [SCORE_BITS-1:0] link_old [PAT_LEN+1];
   logic [1:0]                   rd_dir [PAT_LEN];

   logic             pipe_busy, req_ready, acc, text_acc, pat_acc;
   logic             out_free, hdr_load, run_load;
   logic [1:0]       sym_c, tb_op;
   logic [CW-1:0]    wr_idx;
   logic [AW-1:0]    tb_rd_addr;
   logic [RUN_W-1:0] run_rd;
   cell_ctl_type     sel_ctl;
   logic signed [SCORE_BITS-1:0] sel_new, sel_old;

   assign sym_c    = (32'(req.symbol) >= ALPHABET) ? 2'(ALPHABET - 1) : req.symbol;
   assign acc      = req.valid && req_ready;
   assign text_acc = acc && req.req_type;
   assign pat_acc  = acc && !req.req_type;
   assign wr_idx   = closed_ff ? '0 : count_ff;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign tb_rd_addr = AW'(tb_c_ff - 1'b1);
   assign run_rd   = runs_ff[RW'(r_ff - 1'b1)];
   assign req.ready = req_ready;

   assign link_ctl[0] = inj_ctl_ff;
   assign link_col[0] = inj_col_ff;
   assign link_new[0] = '0;
   assign link_old[0] = '0;

   for (genvar k = 0; k < PAT_LEN; k++) begin : g_cell
      sgac_cell #(.SCORE_BITS(SCORE_BITS), .TEXT_LEN(TEXT_LEN), .AW(AW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .pat_we    (pat_acc && (wr_idx == CW'(k))),
         .pat_sym   (sym_c),
         .sub_table ({sub_hi_ff, sub_lo_ff}),
         .gap_table (gap_ff),
         .in_ctl    (link_ctl[k]),
         .in_col    (link_col[k]),
         .in_new    (link_new[k]),
         .in_old    (link_old[k]),
         .rd_addr   (tb_rd_addr),
         .out_ctl   (link_ctl[k+1]),
         .out_col   (link_col[k+1]),
         .out_new   (link_new[k+1]),
         .out_old   (link_old[k+1]),
         .rd_dir    (rd_dir[k])
      );
   end

   always_comb begin
      pipe_busy = 1'b0;
      for (int k = 0; k <= PAT_LEN; k++) begin
         pipe_busy = pipe_busy | link_ctl[k].valid;
      end
   end

   assign sel_ctl = link_ctl[count_ff];
   assign sel_new = link_new[count_ff];
   assign sel_old = link_old[count_ff];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (text_acc && req.last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!pipe_busy) state_in = (count_ff == '0) ? ST_FLUSH : ST_TB_RD;
         end
         ST_TB_RD: state_in = ST_TB_STEP;
         ST_TB_STEP: begin
            if (tb_op != OP_I && tb_i_ff == CW'(1)) state_in = ST_FLUSH;
            else state_in = ST_TB_RD;
         end
         ST_FLUSH: state_in = ST_HDR;
         ST_HDR: begin
            if (out_free) state_in = (nruns_ff == '0) ? ST_IDLE : ST_RUNS;
         end
         ST_RUNS: begin
            if (out_free && r_ff == NW'(1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE) && (req.req_type || !pipe_busy);
      tb_op     = (tb_c_ff == '0) ? OP_D : rd_dir[RIW'(tb_i_ff - 1'b1)];
      hdr_load  = (state_ff == ST_HDR) && out_free;
      run_load  = (state_ff == ST_RUNS) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sub_lo_ff    <= '0;
         sub_hi_ff    <= '0;
         gap_ff       <= '0;
         count_ff     <= '0;
         closed_ff    <= 1'b0;
         tpos_ff      <= '0;
         best_ff      <= '0;
         bcol_ff      <= '0;
         inj_ctl_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         nruns_ff     <= '0;
         cur_has_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_SUB_LOW:  sub_lo_ff <= csr_wdata;
               CSR_SUB_HIGH: sub_hi_ff <= csr_wdata;
               CSR_GAP:      gap_ff    <= csr_wdata[31:0];
               default: ;
            endcase
         end

         if (pat_acc) begin
            if (32'(wr_idx) < PAT_LEN) count_ff <= wr_idx + 1'b1;
            else count_ff <= wr_idx;
            closed_ff <= req.last;
            tpos_ff   <= '0;
         end
         if (text_acc) begin
            closed_ff <= 1'b1;
            if (32'(tpos_ff) < TEXT_LEN) begin
               inj_ctl_ff <= '{valid: 1'b1, init: (tpos_ff == '0), sym: sym_c};
               inj_col_ff <= AW'(tpos_ff);
               tpos_ff    <= tpos_ff + 1'b1;
            end else begin
               inj_ctl_ff <= '0;
            end
         end else begin
            inj_ctl_ff <= '0;
         end

         if (sel_ctl.valid) begin
            if (sel_ctl.init) begin
               if (sel_new > sel_old) begin
                  best_ff <= sel_new;
                  bcol_ff <= PW'(link_col[count_ff]) + 1'b1;
               end else begin
                  best_ff <= sel_old;
                  bcol_ff <= '0;
               end
            end else if (sel_new > best_ff) begin
               best_ff <= sel_new;
               bcol_ff <= PW'(link_col[count_ff]) + 1'b1;
            end
         end

         if (state_ff == ST_DRAIN && !pipe_busy) begin
            tb_i_ff    <= count_ff;
            tb_c_ff    <= bcol_ff;
            tpos_ff    <= '0;
            nruns_ff   <= '0;
            cur_has_ff <= 1'b0;
         end

         if (state_ff == ST_TB_STEP) begin
            if (tb_op != OP_D) tb_c_ff <= tb_c_ff - 1'b1;
            if (tb_op != OP_I) tb_i_ff <= tb_i_ff - 1'b1;
            if (cur_has_ff && cur_op_ff == tb_op) begin
               cur_len_ff <= cur_len_ff + 1'b1;
            end else begin
               if (cur_has_ff) begin
                  runs_ff[nruns_ff[RW-1:0]] <= {cur_op_ff, cur_len_ff};
                  nruns_ff <= nruns_ff + 1'b1;
               end
               cur_op_ff  <= tb_op;
               cur_len_ff <= LEN_W'(1);
               cur_has_ff <= 1'b1;
            end
         end

         if (state_ff == ST_FLUSH && cur_has_ff) begin
            runs_ff[nruns_ff[RW-1:0]] <= {cur_op_ff, cur_len_ff};
            nruns_ff <= nruns_ff + 1'b1;
         end

         if (hdr_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_kind_ff  <= 1'b0;
            rsp_score_ff <= 16'(32'(best_ff));
            rsp_start_ff <= POS_W'(tb_c_ff);
            rsp_op_ff    <= OP_M;
            rsp_len_ff   <= '0;
            rsp_final_ff <= (nruns_ff == '0);
            r_ff         <= nruns_ff;
         end else if (run_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_kind_ff  <= 1'b1;
            rsp_score_ff <= '0;
            rsp_start_ff <= '0;
            rsp_op_ff    <= run_rd[RUN_W-1:LEN_W];
            rsp_len_ff   <= run_rd[LEN_W-1:0];
            rsp_final_ff <= (r_ff == NW'(1));
            r_ff         <= r_ff - 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.kind       = rsp_kind_ff;
   assign rsp.score      = rsp_score_ff;
   assign rsp.start_pos  = rsp_start_ff;
   assign rsp.op         = rsp_op_ff;
   assign rsp.run_length = rsp_len_ff;
   assign rsp.final_res  = rsp_final_ff;

   a_pat_when_empty: assert property (@(posedge clock) disable iff (reset)
      pat_acc |-> !pipe_busy)
      else $error("pattern item taken while cells busy");

   a_step_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TB_STEP) |-> ($past(state_ff) == ST_TB_RD))
      else $error("traceback step without RAM read");

   a_runs_bound: assert property (@(posedge clock) disable iff (reset)
      32'(nruns_ff) <= MAXRUNS)
      else $error("run buffer overflow");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready)
      else $error("input ready outside idle");
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

import sgac_pkg::*;

typedef struct {
   bit                 kind;
   logic signed [15:0] score;
   logic [10:0]        start_pos;
   logic [1:0]         op;
   logic [10:0]        run_length;
   bit                 final_res;
} result_type;

class align_scoreboard;
   localparam int PLEN = 16;
   localparam int TLEN = 1024;
   localparam int MAXR = 2 * PLEN;

   logic [63:0] sub_lo, sub_hi;
   logic [31:0] gap_tbl;
   logic [1:0]  pat [PLEN];
   int          pat_count;
   bit          pat_closed;
   int          col [PLEN + 1];
   logic [1:0]  dirs [PLEN * TLEN];
   int          text_pos;
   int          best_score;
   int          best_col;
   result_type  expected [$];
   int          errors;

   function new();
      sub_lo = 0;
      sub_hi = 0;
      gap_tbl = 0;
      pat_count = 0;
      pat_closed = 0;
      foreach (col[i]) col[i] = 0;
      text_pos = 0;
      best_score = 0;
      best_col = 0;
      errors = 0;
   endfunction

   function int sat(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function int gap_of(logic [1:0] s);
      logic signed [7:0] b;
      b = gap_tbl[s*8 +: 8];
      return b;
   endfunction

   function int sub_of(logic [1:0] p, logic [1:0] t);
      logic [127:0]      both;
      logic signed [7:0] b;
      both = {sub_hi, sub_lo};
      b = both[{p, t}*8 +: 8];
      return b;
   endfunction

   function void write_reg(logic [1:0] idx, logic [63:0] data);
      if (idx == CSR_SUB_LOW) sub_lo = data;
      else if (idx == CSR_SUB_HIGH) sub_hi = data;
      else if (idx == CSR_GAP) gap_tbl = data[31:0];
   endfunction

   function void push(bit k, int sc, int st, logic [1:0] o, int len, bit f);
      result_type r;
      r.kind = k;
      r.score = 16'(sc);
      r.start_pos = 11'(st);
      r.op = o;
      r.run_length = 11'(len);
      r.final_res = f;
      expected.push_back(r);
   endfunction

   function void traceback();
      int         i, c, nruns;
      logic [1:0] o;
      logic [1:0] run_op [MAXR];
      int         run_len [MAXR];
      i = pat_count;
      c = best_col;
      nruns = 0;
      while (i > 0) begin
         if (c == 0) o = OP_D;
         else o = dirs[(i - 1) * TLEN + c - 1];
         if (o == OP_I) c--;
         else if (o == OP_D) i--;
         else begin
            i--;
            c--;
         end
         if (nruns > 0 && run_op[nruns - 1] == o) run_len[nruns - 1]++;
         else if (nruns < MAXR) begin
            run_op[nruns] = o;
            run_len[nruns] = 1;
            nruns++;
         end
      end
      push(1'b0, best_score, c, OP_M, 0, nruns == 0);
      for (int r = nruns - 1; r >= 0; r--)
         push(1'b1, 0, 0, run_op[r], run_len[r], r == 0);
      text_pos = 0;
   endfunction

   function void note_item(bit is_text, logic [1:0] s, bit lst);
      int         diag, tg, up, del, ins, mm, b;
      logic [1:0] p, d;
      if (!is_text) begin
         if (pat_closed) begin
            pat_count = 0;
            pat_closed = 0;
         end
         if (pat_count < PLEN) begin
            pat[pat_count] = s;
            pat_count++;
         end
         if (lst) pat_closed = 1;
         text_pos = 0;
         return;
      end
      pat_closed = 1;
      if (text_pos == 0) begin
         col[0] = 0;
         for (int i = 1; i <= pat_count; i++) col[i] = sat(col[i - 1] + gap_of(pat[i - 1]));
         best_score = col[pat_count];
         best_col = 0;
      end
      if (text_pos < TLEN) begin
         diag = col[0];
         tg = gap_of(s);
         for (int i = 1; i <= pat_count; i++) begin
            p = pat[i - 1];
            up = col[i];
            del = col[i - 1] + gap_of(p);
            ins = up + tg;
            mm = diag + sub_of(p, s);
            if (del > ins) begin
               b = del;
               d = OP_D;
            end else begin
               b = ins;
               d = OP_I;
            end
            if (!(b > mm)) begin
               b = mm;
               d = (p == s) ? OP_M : OP_X;
            end
            diag = up;
            col[i] = sat(b);
            dirs[(i - 1) * TLEN + text_pos] = d;
         end
         text_pos++;
         if (col[pat_count] > best_score) begin
            best_score = col[pat_count];
            best_col = text_pos;
         end
      end
      if (lst) traceback();
   endfunction

   function void check_result(result_type got);
      result_type want;
      if (expected.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected result item: kind %0d op %0d len %0d",
                                    got.kind, got.op, got.run_length);
         return;
      end
      want = expected.pop_front();
      if (got.kind !== want.kind || got.score !== want.score
          || got.start_pos !== want.start_pos || got.op !== want.op
          || got.run_length !== want.run_length || got.final_res !== want.final_res) begin
         errors++;
         if (errors <= 10) begin
            $display("mismatch: exp kind %0d score %0d start %0d op %0d len %0d fin %0d",
                     want.kind, want.score, want.start_pos, want.op, want.run_length,
                     want.final_res);
            $display("          got kind %0d score %0d start %0d op %0d len %0d fin %0d",
                     got.kind, got.score, got.start_pos, got.op, got.run_length,
                     got.final_res);
         end
      end
   endfunction
endclass

module testbench;
   localparam bit REQ_PAT = 1'b0;
   localparam bit REQ_TXT = 1'b1;
   localparam int LIMIT = 600000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;
   int          cycles;
   int          sent;
   bit          idling;
   bit          hold_rsp;

   align_scoreboard scoreboard;

   sgac_req_if req ();
   sgac_rsp_if rsp ();

   semiglobal_alignment_cigar uut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.kind = rsp.kind;
         got.score = rsp.score;
         got.start_pos = rsp.start_pos;
         got.op = rsp.op;
         got.run_length = rsp.run_length;
         got.final_res = rsp.final_res;
         scoreboard.check_result(got);
      end
   end

   initial begin
      rsp.ready = 0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp.ready <= 0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            rsp.ready <= 0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp.ready <= 1;
            @(posedge clock);
         end
      end
   end

   task automatic send(bit is_text, logic [1:0] s, bit lst);
      req.valid <= 1;
      req.req_type <= is_text;
      req.symbol <= s;
      req.last <= lst;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      scoreboard.note_item(is_text, s, lst);
      sent++;
      if (idling && $urandom_range(0, 4) == 0) begin
         req.valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic send_pattern(int len);
      for (int i = 0; i < len; i++)
         send(REQ_PAT, 2'($urandom_range(0, 3)), i == len - 1);
   endtask

   task automatic send_text(int len);
      for (int i = 0; i < len; i++)
         send(REQ_TXT, 2'($urandom_range(0, 3)), i == len - 1);
   endtask

   task automatic drain();
      req.valid <= 0;
      @(posedge clock);
      while (scoreboard.expected.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic configure(logic [63:0] lo, logic [63:0] hi, logic [31:0] gap);
      drain();
      csr_we <= 1;
      csr_index <= CSR_SUB_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_SUB_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_index <= CSR_GAP;
      csr_wdata <= {32'd0, gap};
      @(posedge clock);
      csr_we <= 0;
      scoreboard.write_reg(CSR_SUB_LOW, lo);
      scoreboard.write_reg(CSR_SUB_HIGH, hi);
      scoreboard.write_reg(CSR_GAP, {32'd0, gap});
   endtask

   function automatic logic [127:0] sub_matrix(logic [7:0] hit, logic [7:0] miss);
      logic [127:0] m;
      for (int p = 0; p < 4; p++)
         for (int t = 0; t < 4; t++) m[(p * 4 + t) * 8 +: 8] = (p == t) ? hit : miss;
      return m;
   endfunction

   task automatic use_scores(logic [7:0] hit, logic [7:0] miss, logic [7:0] gap);
      logic [127:0] m;
      m = sub_matrix(hit, miss);
      configure(m[63:0], m[127:64], {4{gap}});
   endtask

   task automatic random_phase(int items);
      int goal;
      goal = sent + items;
      while (sent < goal) begin
         if ($urandom_range(0, 9) == 0) send_pattern($urandom_range(17, 19));
         else send_pattern($urandom_range(1, 16));
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 7) == 0) begin
               send_text($urandom_range(1, 6) + 1);
               send(REQ_TXT, 2'($urandom_range(0, 3)), 1'b0);
               send(REQ_PAT, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            end else send_text($urandom_range(1, 12));
         end
      end
   endtask

   initial begin
      scoreboard = new();
      cycles = 0;
      sent = 0;
      idling = 1;
      hold_rsp = 0;
      reset = 1;
      csr_we = 0;
      csr_index = CSR_SUB_LOW;
      csr_wdata = 0;
      req.valid = 0;
      req.req_type = REQ_PAT;
      req.symbol = 0;
      req.last = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send(REQ_TXT, 2'd3, 1'b1);
      use_scores(8'sd2, -8'sd1, -8'sd2);
      send(REQ_PAT, 2'd0, 1'b0);
      send(REQ_PAT, 2'd1, 1'b0);
      send(REQ_PAT, 2'd2, 1'b0);
      send(REQ_PAT, 2'd3, 1'b1);
      for (int t = 0; t < 6; t++) send(REQ_TXT, 2'(t % 4), t == 5);
      send(REQ_TXT, 2'd1, 1'b1);
      send_pattern(18);
      send_text(4);
      send(REQ_TXT, 2'd2, 1'b0);
      send(REQ_PAT, 2'd1, 1'b1);
      send_text(3);

      use_scores(8'sd127, 8'sd127, 8'sd127);
      send_pattern(2);
      send_text(12);
      use_scores(-8'sd128, -8'sd128, -8'sd128);
      send_pattern(16);
      send_text(5);

      configure({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      random_phase(12);
      hold_rsp = 1;
      send_pattern(8);
      send_text(8);
      send_text(8);
      drain();
      use_scores(8'sd3, -8'sd2, -8'sd3);
      random_phase(10);
      drain();
      idling = 0;
      use_scores(8'sd1, -8'sd1, -8'sd1);
      random_phase(12);

      drain();
      if (scoreboard.errors == 0 && scoreboard.expected.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

// ===== files.f =====
sv/sgac_pkg.sv
sv/sgac_if.sv
sv/sgac_ram.sv
sv/sgac_cell.sv
sv/semiglobal_alignment_cigar.sv
tb/testbench.sv
